// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define STEM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Check that an antecedent implies a consequent in the next cycle.
`define STEM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/stem_pkg.sv -----
package stem_pkg;

  localparam int MaxDelay   = 32768;
  localparam int AddrW      = $clog2(MaxDelay);
  localparam int SampleBits = 16;
  localparam int GainW      = 16;
  localparam int FracBits   = 12;
  localparam int ProdW      = SampleBits + GainW + 1;
  localparam int SumW       = ProdW + 1;
  localparam int WordW      = 2 * SampleBits;
  localparam int CountW     = 32;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 16;

  localparam logic [CfgIdxW-1:0] CFG_DELAY  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_GAIN   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_STEREO = 2'd2;

  localparam logic [AddrW-1:0] DelayReset = AddrW'(4800);
  localparam logic [GainW-1:0] GainReset  = GainW'(2048);

  typedef struct packed {
    logic                         mode;
    logic signed [SampleBits-1:0] in_left;
    logic signed [SampleBits-1:0] in_right;
  } stem_in_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] out_left;
    logic signed [SampleBits-1:0] out_right;
    logic                         left_clipped;
    logic                         right_clipped;
    logic [CountW-1:0]            clip_total;
  } stem_out_t;

  typedef struct packed {
    logic                         valid;
    logic                         st;
    logic                         echo;
    logic signed [SampleBits-1:0] dl;
    logic signed [SampleBits-1:0] dr;
  } stem_lane_t;

  typedef struct packed {
    logic                         clip;
    logic signed [SampleBits-1:0] value;
  } stem_sat_t;

  function automatic stem_sat_t stem_saturate(input logic signed [SumW-1:0] s);
    stem_sat_t r;
    logic signed [SumW-1:0] maxv;
    logic signed [SumW-1:0] minv;
    maxv = SumW'((64'sd1 <<< (SampleBits - 1)) - 64'sd1);
    minv = -SumW'(64'sd1 <<< (SampleBits - 1));
    if (s > maxv) begin
      r.clip  = 1'b1;
      r.value = maxv[SampleBits-1:0];
    end else if (s < minv) begin
      r.clip  = 1'b1;
      r.value = minv[SampleBits-1:0];
    end else begin
      r.clip  = 1'b0;
      r.value = s[SampleBits-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/stem_ram.sv -----
module stem_ram #(
  parameter int Width = 32,
  parameter int Depth = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/stem_mix.sv -----
module stem_mix import stem_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  stem_lane_t           lane_i,
  input  logic [WordW-1:0]     rdata_i,
  input  logic [GainW-1:0]     gain_i,
  output logic                 adv_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output stem_out_t            out_item_o
);

  logic                         adv;
  logic signed [SampleBits-1:0] el;
  logic signed [SampleBits-1:0] er;
  logic signed [GainW:0]        g;
  logic signed [ProdW-1:0]      pl_d, pr_d;
  logic signed [ProdW-1:0]      pl_q, pr_q;
  logic                         s2_valid_q;
  logic                         s2_st_q;
  logic signed [SampleBits-1:0] s2_dl_q, s2_dr_q;
  logic signed [SumW-1:0]       sum_l, sum_r;
  stem_sat_t                    sat_l, sat_r;
  logic                         cl, cr;
  logic [CountW:0]              cnt_sum;
  logic [CountW-1:0]            cnt_d, cnt_q;
  logic                         out_valid_q;
  stem_out_t                    out_d, out_q;

  assign adv   = !out_valid_q || out_ready_i;
  assign adv_o = adv;

  assign el   = lane_i.echo ? $signed(rdata_i[SampleBits-1:0]) : '0;
  assign er   = lane_i.echo ? $signed(rdata_i[WordW-1:SampleBits]) : '0;
  assign g    = $signed({1'b0, gain_i});
  assign pl_d = ProdW'(el) * ProdW'(g);
  assign pr_d = ProdW'(er) * ProdW'(g);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= lane_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pl_q    <= pl_d;
      pr_q    <= pr_d;
      s2_st_q <= lane_i.st;
      s2_dl_q <= lane_i.dl;
      s2_dr_q <= lane_i.dr;
    end
  end

  assign sum_l = SumW'(pl_q >>> FracBits) + SumW'(s2_dl_q);
  assign sum_r = SumW'(pr_q >>> FracBits) + SumW'(s2_dr_q);
  assign sat_l = stem_saturate(sum_l);
  assign sat_r = stem_saturate(sum_r);
  assign cl    = sat_l.clip;
  assign cr    = s2_st_q && sat_r.clip;

  assign cnt_sum = {1'b0, cnt_q} + (CountW + 1)'(cl) + (CountW + 1)'(cr);
  assign cnt_d   = cnt_sum[CountW] ? '1 : cnt_sum[CountW-1:0];

  always_comb begin
    out_d.out_left      = sat_l.value;
    out_d.out_right     = s2_st_q ? sat_r.value : '0;
    out_d.left_clipped  = cl;
    out_d.right_clipped = cr;
    out_d.clip_total    = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else if (adv) begin
      out_valid_q <= s2_valid_q;
      if (s2_valid_q) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- hdl/single_tap_echo_mixer_unit.sv -----
// Stages: lane and memory read registers, product register, result register.
// Throughput: one item per cycle unless the output stalls. The delay memory has
// one write and one read port: an item writes its frame and reads its echo in
// the same cycle. Reset clears the write pointer, fill count, clip counter and
// pipeline valids and loads register defaults; delay memory is not cleared.
`include "assert_macros.svh"

module single_tap_echo_mixer_unit import stem_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  stem_in_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output stem_out_t           out_item_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  logic [AddrW-1:0]             delay_q;
  logic [GainW-1:0]             gain_q;
  logic                         stereo_q;
  logic [AddrW-1:0]             wp_q, fill_q;
  logic                         adv;
  logic                         in_acc;
  logic                         echo;
  logic signed [SampleBits-1:0] dl, dr;
  logic [AddrW-1:0]             raddr;
  logic [WordW-1:0]             rdata;
  stem_lane_t                   lane_d, lane_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q  <= DelayReset;
      gain_q   <= GainReset;
      stereo_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DELAY:  delay_q  <= cfg_wdata_i[AddrW-1:0];
        CFG_GAIN:   gain_q   <= cfg_wdata_i[GainW-1:0];
        CFG_STEREO: stereo_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = adv;
  assign in_acc     = in_valid_i && adv;

  assign dl    = in_item_i.mode ? '0 : in_item_i.in_left;
  assign dr    = (in_item_i.mode || !stereo_q) ? '0 : in_item_i.in_right;
  assign echo  = (delay_q != '0) && (fill_q >= delay_q);
  assign raddr = wp_q - delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
    end else if (in_acc) begin
      wp_q <= wp_q + AddrW'(1);
      if (fill_q != '1) begin
        fill_q <= fill_q + AddrW'(1);
      end
    end
  end

  stem_ram #(
    .Width (WordW),
    .Depth (MaxDelay)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (wp_q),
    .wdata_i ({dr, dl}),
    .re_i    (in_acc),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    lane_d.valid = in_acc;
    lane_d.st    = stereo_q;
    lane_d.echo  = echo;
    lane_d.dl    = dl;
    lane_d.dr    = dr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q <= '0;
    end else if (adv) begin
      lane_q <= lane_d;
    end
  end

  stem_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lane_i      (lane_q),
    .rdata_i     (rdata),
    .gain_i      (gain_q),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  `STEM_ASSERT(a_no_rw_clash, clk_i, rst_ni, !(in_acc && echo) || (raddr != wp_q))
  `STEM_ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, in_acc, lane_q.valid)
  `STEM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_item_o))

endmodule

// ----- tb/sv/single_tap_echo_mixer_unit_test.sv -----
`timescale 1ns / 1ps

module single_tap_echo_mixer_unit_test import stem_pkg::*; ();

  localparam int QuietLimit = 1000;

  class echo_mix_board;
    logic [WordW-1:0]  echo_mem [MaxDelay];
    logic [AddrW-1:0]  wr_ptr;
    int unsigned       fill;
    logic [CountW-1:0] clips;
    logic [AddrW-1:0]  delay_cfg;
    logic [GainW-1:0]  gain_cfg;
    logic              stereo_cfg;
    stem_out_t         pending_mixes[$];
    int unsigned       frames_seen;
    int unsigned       mixes_checked;
    int unsigned       clipped_seen;
    int unsigned       mismatches;

    function new();
      wr_ptr        = '0;
      fill          = 0;
      clips         = '0;
      delay_cfg     = DelayReset;
      gain_cfg      = GainReset;
      stereo_cfg    = 1'b1;
      frames_seen   = 0;
      mixes_checked = 0;
      clipped_seen  = 0;
      mismatches    = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_DELAY: delay_cfg = data[AddrW-1:0];
        CFG_GAIN: gain_cfg = data[GainW-1:0];
        CFG_STEREO: stereo_cfg = data[0];
        default: ;
      endcase
    endfunction

    function logic [SampleBits-1:0] mix_sample(int dry, int dly, output logic clip);
      longint sum;
      longint maxv;
      longint minv;
      maxv = (longint'(1) <<< (SampleBits - 1)) - 1;
      minv = -(longint'(1) <<< (SampleBits - 1));
      sum  = longint'(dry) + ((longint'(dly) * longint'(gain_cfg)) >>> FracBits);
      clip = 1'b1;
      if (sum > maxv) return SampleBits'(maxv);
      if (sum < minv) return SampleBits'(minv);
      clip = 1'b0;
      return SampleBits'(sum);
    endfunction

    function void note_frame(stem_in_t f);
      int               dl;
      int               dr;
      int               el;
      int               er;
      logic             cl;
      logic             cr;
      logic [AddrW-1:0] rd;
      logic [WordW-1:0] w;
      stem_out_t        r;
      dl = f.mode ? 0 : int'(f.in_left);
      dr = (f.mode || !stereo_cfg) ? 0 : int'(f.in_right);
      el = 0;
      er = 0;
      cr = 1'b0;
      if (delay_cfg != 0 && fill >= delay_cfg) begin
        rd = wr_ptr - delay_cfg;
        w  = echo_mem[rd];
        el = $signed(w[SampleBits-1:0]);
        er = $signed(w[WordW-1:SampleBits]);
      end
      r = '0;
      r.out_left = mix_sample(dl, el, cl);
      if (stereo_cfg) r.out_right = mix_sample(dr, er, cr);
      r.left_clipped  = cl;
      r.right_clipped = cr;
      echo_mem[wr_ptr] = {SampleBits'(dr), SampleBits'(dl)};
      wr_ptr = wr_ptr + 1'b1;
      if (fill < MaxDelay - 1) fill++;
      if (cl && clips != '1) clips++;
      if (cr && clips != '1) clips++;
      r.clip_total = clips;
      pending_mixes.push_back(r);
      frames_seen++;
    endfunction

    function void check_mix(stem_out_t got);
      stem_out_t want;
      if (pending_mixes.size() == 0) begin
        $error("result with no item pending: %p", got);
        mismatches++;
        return;
      end
      want = pending_mixes.pop_front();
      mixes_checked++;
      if (want.left_clipped || want.right_clipped) clipped_seen++;
      if (got.out_left !== want.out_left) begin
        $error("out_left expected %0d actual %0d", want.out_left, got.out_left);
        mismatches++;
      end
      if (got.out_right !== want.out_right) begin
        $error("out_right expected %0d actual %0d", want.out_right, got.out_right);
        mismatches++;
      end
      if (got.left_clipped !== want.left_clipped) begin
        $error("left_clipped expected %0b actual %0b", want.left_clipped, got.left_clipped);
        mismatches++;
      end
      if (got.right_clipped !== want.right_clipped) begin
        $error("right_clipped expected %0b actual %0b", want.right_clipped,
               got.right_clipped);
        mismatches++;
      end
      if (got.clip_total !== want.clip_total) begin
        $error("clip_total expected %0d actual %0d", want.clip_total, got.clip_total);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                frame_valid = 1'b0;
  logic                frame_ready;
  stem_in_t            frame = '0;
  logic                mix_valid;
  logic                mix_ready = 1'b0;
  stem_out_t           mix;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = CFG_DELAY;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                idle_on = 1'b0;
  int unsigned         stall_left = 0;
  int unsigned         quiet_cycles = 0;
  echo_mix_board       board = new();

  single_tap_echo_mixer_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (frame_valid),
    .in_ready_o  (frame_ready),
    .in_item_i   (frame),
    .out_valid_o (mix_valid),
    .out_ready_i (mix_ready),
    .out_item_o  (mix),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (mix_valid && mix_ready) board.check_mix(mix);
      if (frame_valid && frame_ready) board.note_frame(frame);
    end
  end

  always @(posedge clk) begin
    if (!idle_on) begin
      stall_left <= 0;
      mix_ready  <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      mix_ready  <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 8);
      mix_ready  <= 1'b0;
    end else begin
      mix_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((frame_valid && frame_ready) || (mix_valid && mix_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [SampleBits-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return SampleBits'($urandom);
    endcase
  endfunction

  function automatic stem_in_t random_frame();
    stem_in_t f;
    f.mode     = ($urandom_range(0, 7) == 0);
    f.in_left  = pick_sample();
    f.in_right = pick_sample();
    return f;
  endfunction

  task automatic send_frame(input stem_in_t f);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      frame_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    frame_valid <= 1'b1;
    frame       <= f;
    do @(posedge clk); while (!frame_ready);
  endtask

  task automatic drain();
    frame_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_mixes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [CfgDataW-1:0] dly_word,
                           input logic [CfgDataW-1:0] gain_word,
                           input logic [CfgDataW-1:0] mode_word);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_DELAY;
    cfg_wdata <= dly_word;
    @(posedge clk);
    board.set_reg(CFG_DELAY, dly_word);
    cfg_idx   <= CFG_GAIN;
    cfg_wdata <= gain_word;
    @(posedge clk);
    board.set_reg(CFG_GAIN, gain_word);
    cfg_idx   <= CFG_STEREO;
    cfg_wdata <= mode_word;
    @(posedge clk);
    board.set_reg(CFG_STEREO, mode_word);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [CfgDataW-1:0] dly_word;
    logic [CfgDataW-1:0] gain_word;
    logic [CfgDataW-1:0] mode_word;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    configure(3, 65535, 1);
    send_frame('{1'b0, 16'sh7FFF, 16'sh8000});
    send_frame('{1'b0, 16'sh8000, 16'sh7FFF});
    send_frame('{1'b0, 16'shFFFF, 16'sh0001});
    send_frame('{1'b0, 16'sh7FFF, 16'sh8000});
    send_frame('{1'b0, 16'sh0000, 16'sh0000});
    send_frame('{1'b0, 16'sh0000, 16'sh0000});
    send_frame('{1'b1, 16'sh0064, 16'shFF9C});
    drain();

    configure(1, 1, 0);
    send_frame('{1'b0, 16'shFFFF, 16'sh7FFF});
    send_frame('{1'b0, 16'sh0064, 16'shFFF9});
    send_frame('{1'b0, 16'sh8000, 16'sh0005});
    send_frame('{1'b0, 16'sh8000, 16'sh0000});
    send_frame('{1'b1, 16'sh0007, 16'sh0007});
    drain();

    configure(16'h8000, 4096, 16'hFFFE | 16'h0001);
    send_frame('{1'b0, 16'sh3039, 16'shCFC7});
    send_frame('{1'b0, 16'shFFFE, 16'sh0002});
    drain();

    configure(2, 4095, 1);
    send_frame('{1'b0, 16'sh7FFF, 16'sh7FFF});
    send_frame('{1'b0, 16'sh8000, 16'sh8000});
    send_frame('{1'b0, 16'sh0001, 16'shFFFF});
    send_frame('{1'b0, 16'sh0001, 16'shFFFF});
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 5))
        0: dly_word = 1;
        1: dly_word = 0;
        2: dly_word = $urandom_range(1, 8);
        3: dly_word = $urandom_range(1, 150);
        4: dly_word = $urandom_range(1, 600);
        default: dly_word = 2;
      endcase
      dly_word[CfgDataW-1] = 1'($urandom);
      case ($urandom_range(0, 5))
        0: gain_word = 0;
        1: gain_word = 16'hFFFF;
        2: gain_word = 4096;
        3: gain_word = 1;
        default: gain_word = CfgDataW'($urandom);
      endcase
      mode_word = CfgDataW'($urandom);
      configure(dly_word, gain_word, mode_word);
      idle_on <= ($urandom_range(0, 3) != 0);
      repeat (200) send_frame(random_frame());
      drain();
    end

    configure(16'hFFFF, CfgDataW'($urandom_range(1, 65535)), 1);
    idle_on <= 1'b0;
    repeat (200) send_frame(random_frame());
    drain();

    configure(CfgDataW'($urandom_range(1, 64)), CfgDataW'($urandom), 1);
    repeat (100) send_frame(random_frame());
    drain();

    $display("Mixed %0d frames, checked %0d results, %0d of them clipped.",
             board.frames_seen, board.mixes_checked, board.clipped_seen);
    $display("Ran mono and stereo, flush frames and delays 0 to %0d under random stalls.",
             MaxDelay - 1);
    if (board.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
